// ===== rtl/tnwc_pkg.sv =====
`default_nettype none
package tnwc_pkg;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int CW = COORD_WIDTH_DEF;

	typedef struct packed {
		logic signed [CW-1:0] in_x;
		logic signed [CW-1:0] in_y;
		logic signed [CW-1:0] in_z;
		logic signed [CW-1:0] in_w;
	} vin_t;

	typedef struct packed {
		logic signed [CW-1:0] out_x;
		logic signed [CW-1:0] out_y;
		logic signed [CW-1:0] out_z;
		logic signed [CW-1:0] out_w;
		logic                 end_of_triangle;
		logic                 last_of_run;
	} vout_t;

	// classified triangle handed from the front to the back
	typedef struct packed {
		logic [2:0]           bad;
		logic signed [CW-1:0] thr;
		logic [11:0][CW-1:0]  c;
	} tri_t;
endpackage
`default_nettype wire

// ===== rtl/tnwc_front.sv =====
`default_nettype none
module tnwc_front import tnwc_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	output logic                      full,
	input  wire vin_t                 din,
	input  wire logic signed [CW-1:0] thr,
	output logic                      tri_valid,
	input  wire logic                 tri_ready,
	output tri_t                      tri_out
);
	logic [1:0] cnt_q;
	logic [CW-1:0] held_q [8];
	logic [2:0] bad;
	logic [11:0][CW-1:0] c;
	logic acc;

	// hold the queue toward the back: one triangle slot
	logic vq_q;
	tri_t tq_q;

	assign full = (cnt_q == 2'd2) && vq_q && !tri_ready;
	assign acc  = push && !full;

	always_comb begin
		for (int i = 0; i < 8; i++) c[i] = held_q[i];
		c[8]  = din.in_x;
		c[9]  = din.in_y;
		c[10] = din.in_z;
		c[11] = din.in_w;
		for (int i = 0; i < 3; i++) bad[i] = $signed(c[i*4+3]) <= thr;
	end

	always_ff @(posedge clk) begin
		if (acc && cnt_q != 2'd2) begin
			held_q[{cnt_q[0], 2'd0}] <= din.in_x;
			held_q[{cnt_q[0], 2'd1}] <= din.in_y;
			held_q[{cnt_q[0], 2'd2}] <= din.in_z;
			held_q[{cnt_q[0], 2'd3}] <= din.in_w;
		end
		if (acc && cnt_q == 2'd2) begin
			tq_q.bad <= bad;
			tq_q.thr <= thr;
			tq_q.c   <= c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			vq_q  <= 1'b0;
		end else begin
			// drop fully clipped triangles here
			if (acc && cnt_q == 2'd2 && bad != 3'b111) vq_q <= 1'b1;
			else if (tri_valid && tri_ready) vq_q <= 1'b0;
			if (acc) begin
				if (cnt_q == 2'd2) cnt_q <= 2'd0;
				else cnt_q <= cnt_q + 2'd1;
			end
		end
	end

	assign tri_valid = vq_q;
	assign tri_out   = tq_q;
endmodule
`default_nettype wire

// ===== rtl/tnwc_div.sv =====
`default_nettype none
module tnwc_div import tnwc_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [CW-1:0] mag,
	input  wire logic [CW-1:0] num,
	input  wire logic [CW-1:0] den,
	output logic               done,
	output logic [CW-1:0]      q
);
	// mag*num/den rounded, one bit per cycle; r stays below den
	localparam int BW = $clog2(CW);
	logic [CW:0]   r_q;
	logic [CW-1:0] q_q, mag_q, num_q, den_q;
	logic [BW-1:0] bit_q;
	logic          busy_q, fin_q;
	logic [CW:0]   r1, r2;
	logic [CW-1:0] q1, q2;

	always_comb begin
		if (r_q >= {1'b0, den_q} - r_q) begin
			r1 = r_q - ({1'b0, den_q} - r_q);
			q1 = {q_q[CW-2:0], 1'b1};
		end else begin
			r1 = r_q << 1;
			q1 = {q_q[CW-2:0], 1'b0};
		end
		r2 = r1;
		q2 = q1;
		if (mag_q[bit_q]) begin
			if (r1 >= {1'b0, den_q - num_q}) begin
				r2 = r1 - {1'b0, den_q - num_q};
				q2 = q1 + CW'(1);
			end else begin
				r2 = r1 + {1'b0, num_q};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= mag;
			num_q <= num;
			den_q <= den;
			r_q   <= '0;
			q_q   <= '0;
			bit_q <= BW'(CW-1);
		end else if (busy_q) begin
			r_q   <= r2;
			q_q   <= q2;
			bit_q <= bit_q - BW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
		end else begin
			fin_q <= busy_q && bit_q == '0;
			if (start) busy_q <= 1'b1;
			else if (busy_q && bit_q == '0) busy_q <= 1'b0;
		end
	end

	assign done = fin_q;
	assign q    = q_q + {{(CW-1){1'b0}}, (r_q >= {1'b0, den_q} - r_q)};
endmodule
`default_nettype wire

// ===== rtl/tnwc_back.sv =====
`default_nettype none
module tnwc_back import tnwc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic tri_valid,
	output logic      tri_ready,
	input  wire tri_t tri_in,
	output logic      empty,
	input  wire logic pop,
	output vout_t     dout
);
	localparam logic [2:0] S_IDLE = 3'd0, S_DIV = 3'd1, S_WAIT = 3'd2, S_EMIT = 3'd3;

	logic [2:0]  st_q;
	tri_t        t_q;
	logic [11:0][CW-1:0] v_q;   // first output triangle
	logic [11:0][CW-1:0] v2_q;  // second output triangle
	logic        two_q;
	logic [1:0]  bi_q, g0_q, g1_q;
	logic [1:0]  job_q;         // coordinate 0..2
	logic        pass_q;        // 0: toward g0 / first bad, 1: second
	logic [2:0]  oi_q;
	logic [1:0]  nb;
	logic [1:0]  bsel, gsel;
	logic [CW-1:0] cb, cg, wb, wg, mag, num, den;
	logic        neg, dstart, ddone;
	logic [CW-1:0] dq, res;

	always_comb begin
		nb = 2'(tri_in.bad[0]) + 2'(tri_in.bad[1]) + 2'(tri_in.bad[2]);
		// two bad: the second pass moves the bad vertex in g1 toward g0
		bsel = (two_q && pass_q) ? g1_q : bi_q;
		gsel = (!two_q && pass_q) ? g1_q : g0_q;
		cb  = t_q.c[{bsel, job_q}];
		cg  = t_q.c[{gsel, job_q}];
		wb  = t_q.c[{bsel, 2'd3}];
		wg  = t_q.c[{gsel, 2'd3}];
		neg = $signed(cb) > $signed(cg);
		mag = neg ? cb - cg : cg - cb;
		num = t_q.thr - wb;
		den = wg - wb;
		res = neg ? cb - dq : cb + dq;
	end

	tnwc_div u_div (.clk, .arst_n, .start(dstart), .mag, .num, .den,
		.done(ddone), .q(dq));

	assign dstart    = st_q == S_DIV;
	assign tri_ready = st_q == S_IDLE;

	always_ff @(posedge clk) begin
		if (tri_valid && tri_ready) t_q <= tri_in;
		if (st_q == S_IDLE && tri_valid) begin
			v_q  <= tri_in.c;
			v2_q <= tri_in.c;
			two_q <= nb == 2'd2;
			// two_q meaning: bi = first bad, g0 = good, g1 = second bad
			if (nb == 2'd2) begin
				bi_q <= tri_in.bad[0] ? 2'd0 : 2'd1;
				g0_q <= !tri_in.bad[0] ? 2'd0 : (!tri_in.bad[1] ? 2'd1 : 2'd2);
				g1_q <= tri_in.bad[2] ? 2'd2 : 2'd1;
			end else begin
				bi_q <= tri_in.bad[0] ? 2'd0 : (tri_in.bad[1] ? 2'd1 : 2'd2);
				g0_q <= tri_in.bad[0] ? 2'd1 : 2'd0;
				g1_q <= tri_in.bad[2] ? 2'd1 : 2'd2;
			end
		end
		if (st_q == S_WAIT && ddone) begin
			if (two_q) begin
				v_q[{pass_q ? g1_q : bi_q, job_q}] <= res;
				if (job_q == 2'd2) v_q[{pass_q ? g1_q : bi_q, 2'd3}] <= t_q.thr;
			end else if (!pass_q) begin
				v_q[{bi_q, job_q}]  <= res;
				v2_q[{bi_q, job_q}] <= res;
				if (job_q == 2'd2) begin
					v_q[{bi_q, 2'd3}]  <= t_q.thr;
					v2_q[{bi_q, 2'd3}] <= t_q.thr;
				end
			end else begin
				v2_q[{g0_q, job_q}] <= res;
				if (job_q == 2'd2) v2_q[{g0_q, 2'd3}] <= t_q.thr;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			job_q  <= 2'd0;
			pass_q <= 1'b0;
			oi_q   <= 3'd0;
		end else begin
			case (st_q)
				S_IDLE: if (tri_valid) begin
					job_q  <= 2'd0;
					pass_q <= 1'b0;
					oi_q   <= 3'd0;
					st_q   <= (nb == 2'd0) ? S_EMIT : S_DIV;
				end
				S_DIV: st_q <= S_WAIT;
				S_WAIT: if (ddone) begin
					if (job_q == 2'd2) begin
						job_q <= 2'd0;
						if (pass_q) st_q <= S_EMIT;
						else begin
							pass_q <= 1'b1;
							st_q   <= S_DIV;
						end
					end else begin
						job_q <= job_q + 2'd1;
						st_q  <= S_DIV;
					end
				end
				S_EMIT: if (pop) begin
					if (oi_q == ((two_q || t_q.bad == 3'b000) ? 3'd2 : 3'd5))
						st_q <= S_IDLE;
					oi_q <= oi_q + 3'd1;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	logic [1:0] vi;
	logic       one;
	always_comb begin
		one = !two_q && t_q.bad != 3'b000;
		vi  = (oi_q >= 3'd3) ? 2'(oi_q - 3'd3) : oi_q[1:0];
		if (oi_q >= 3'd3) begin
			dout.out_x = v2_q[{vi, 2'd0}];
			dout.out_y = v2_q[{vi, 2'd1}];
			dout.out_z = v2_q[{vi, 2'd2}];
			dout.out_w = v2_q[{vi, 2'd3}];
		end else begin
			dout.out_x = v_q[{vi, 2'd0}];
			dout.out_y = v_q[{vi, 2'd1}];
			dout.out_z = v_q[{vi, 2'd2}];
			dout.out_w = v_q[{vi, 2'd3}];
		end
		dout.end_of_triangle = vi == 2'd2;
		dout.last_of_run     = one ? oi_q == 3'd5 : oi_q == 3'd2;
	end

	assign empty = st_q != S_EMIT;
endmodule
`default_nettype wire

// ===== rtl/triangle_near_w_clipper.sv =====
`default_nettype none
// Near-plane triangle clipper against w = thr_q, the threshold register.
// Input queue: push a vertex request while full is low; every third vertex
// closes a triangle. Output queue: while empty is low the oldest result
// vertex is on dout; pop takes it. end_of_triangle marks each third emitted
// vertex, last_of_run the final vertex for the input triangle.
// The front holds the first two vertices, classifies all three when the
// closing one arrives and parks the triangle in a one-slot queue. The back
// moves bad vertices with an iterative divider, one quotient bit per cycle;
// three coordinates per moved point, two points per clipped triangle. An
// unclipped triangle's first result shows once it has passed the front slot
// and the back's capture registers; a clipped one first runs its divisions.
// The back then hands out one result per pop and takes no new triangle until
// its last result is popped. Triangles with all vertices bad are dropped at
// once. Vertices are taken one per cycle while the slot is free.
// Reset clears counts and queues; the threshold returns to 1/100.
// When the receiver stalls, results wait on dout, the back stops and the
// front keeps taking vertices until a closing vertex finds its slot occupied.
module triangle_near_w_clipper import tnwc_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	output logic                 full,
	input  wire vin_t            din,
	output logic                 empty,
	input  wire logic            pop,
	output vout_t                dout,
	input  wire logic            cfg_we,
	input  wire logic [CW-1:0]   cfg_wdata
);
	localparam logic [CW-1:0] THR_RST = CW'((64'd1 << FRAC_BITS) / 64'd100);
	logic signed [CW-1:0] thr_q;
	logic tri_valid, tri_ready;
	tri_t tri_d;

	// load the threshold register from cfg_wdata on a write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thr_q <= THR_RST;
		else if (cfg_we) thr_q <= cfg_wdata;
	end

	tnwc_front u_front (.clk, .arst_n, .push, .full, .din, .thr(thr_q),
		.tri_valid, .tri_ready, .tri_out(tri_d));
	tnwc_back u_back (.clk, .arst_n, .tri_valid, .tri_ready, .tri_in(tri_d),
		.empty, .pop, .dout);
endmodule
`default_nettype wire

// ===== rtl/tnwc_chk.sv =====
`default_nettype none
module tnwc_chk import tnwc_pkg::*; (
	input wire logic  clk,
	input wire logic  arst_n,
	input wire logic  full,
	input wire logic  empty,
	input wire logic  pop,
	input wire vout_t dout
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(dout)) else $error("result changed");
	a_clip_w: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && dout.last_of_run |-> dout.end_of_triangle) else $error("bad last");
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({full, empty})) else $error("unknown flag");
endmodule
bind triangle_near_w_clipper tnwc_chk u_chk (.clk, .arst_n, .full, .empty, .pop, .dout);
`default_nettype wire

// ===== dv/tb_triangle_near_w_clipper.sv =====
`timescale 1ns / 100ps

// Scoreboard for the near-w clipper: tracks the two held vertices and the
// threshold, and queues the vertices that each closed triangle must produce.
class clip_scoreboard;
	tnwc_pkg::vin_t  held [2];
	int              held_cnt;
	logic [31:0]     thr;
	tnwc_pkg::vout_t want_q [$];
	int              tri_n, emit_n, err_n;

	function new();
		held_cnt = 0;
		thr = 32'd655;
		tri_n = 0;
		emit_n = 0;
		err_n = 0;
	endfunction

	function int pending();
		return want_q.size();
	endfunction

	// Round |g-b|*num/den to nearest, ties away from zero, apply with sign of g-b.
	function logic [31:0] lerp(logic signed [31:0] cb, logic signed [31:0] cg,
			logic [63:0] num, logic [63:0] den);
		logic signed [63:0] b, g;
		logic [127:0] mag, q, n, d;
		b = cb;
		g = cg;
		mag = (b > g) ? 128'(b - g) : 128'(g - b);
		n = 128'(num);
		d = 128'(den);
		q = (mag * n * 2 + d) / (d * 2);
		return (b > g) ? 32'(b - 64'(q)) : 32'(b + 64'(q));
	endfunction

	// Slide a bad vertex along its edge until w sits on the threshold.
	function tnwc_pkg::vin_t move_to_plane(tnwc_pkg::vin_t b, tnwc_pkg::vin_t g);
		tnwc_pkg::vin_t r;
		logic signed [63:0] wb, wg, t;
		logic [63:0] num, den;
		wb = b.in_w;
		wg = g.in_w;
		t = $signed(thr);
		num = 64'(t - wb);
		den = 64'(wg - wb);
		r.in_x = lerp(b.in_x, g.in_x, num, den);
		r.in_y = lerp(b.in_y, g.in_y, num, den);
		r.in_z = lerp(b.in_z, g.in_z, num, den);
		r.in_w = thr;
		return r;
	endfunction

	function void queue_triangle(tnwc_pkg::vin_t t [3], bit last_tri);
		tnwc_pkg::vout_t o;
		for (int i = 0; i < 3; i++) begin
			o.out_x = t[i].in_x;
			o.out_y = t[i].in_y;
			o.out_z = t[i].in_z;
			o.out_w = t[i].in_w;
			o.end_of_triangle = (i == 2);
			o.last_of_run = (i == 2) && last_tri;
			want_q.push_back(o);
		end
	endfunction

	// Note an accepted vertex request; a closing vertex yields 0, 3 or 6 results.
	function void take_vertex(tnwc_pkg::vin_t v);
		tnwc_pkg::vin_t t [3];
		int bad_i [$];
		int good_i [$];
		tnwc_pkg::vin_t p0, p1;
		if (held_cnt < 2) begin
			held[held_cnt] = v;
			held_cnt++;
			return;
		end
		held_cnt = 0;
		tri_n++;
		t[0] = held[0];
		t[1] = held[1];
		t[2] = v;
		for (int i = 0; i < 3; i++) begin
			if ($signed(t[i].in_w) <= $signed(thr))
				bad_i.push_back(i);
			else
				good_i.push_back(i);
		end
		case (bad_i.size())
			0: queue_triangle(t, 1'b1);
			2: begin
				t[bad_i[0]] = move_to_plane(t[bad_i[0]], t[good_i[0]]);
				t[bad_i[1]] = move_to_plane(t[bad_i[1]], t[good_i[0]]);
				queue_triangle(t, 1'b1);
			end
			1: begin
				p0 = move_to_plane(t[bad_i[0]], t[good_i[0]]);
				p1 = move_to_plane(t[bad_i[0]], t[good_i[1]]);
				t[bad_i[0]] = p0;
				queue_triangle(t, 1'b0);
				t[good_i[0]] = p1;
				queue_triangle(t, 1'b1);
			end
			default: ;
		endcase
	endfunction

	function void check_vertex(tnwc_pkg::vout_t got);
		tnwc_pkg::vout_t w;
		emit_n++;
		if (want_q.size() == 0) begin
			$error("unexpected result vertex x=%h w=%h", got.out_x, got.out_w);
			err_n++;
			return;
		end
		w = want_q.pop_front();
		if (got.out_x !== w.out_x) begin
			$error("out_x exp %h got %h", w.out_x, got.out_x);
			err_n++;
		end
		if (got.out_y !== w.out_y) begin
			$error("out_y exp %h got %h", w.out_y, got.out_y);
			err_n++;
		end
		if (got.out_z !== w.out_z) begin
			$error("out_z exp %h got %h", w.out_z, got.out_z);
			err_n++;
		end
		if (got.out_w !== w.out_w) begin
			$error("out_w exp %h got %h", w.out_w, got.out_w);
			err_n++;
		end
		if (got.end_of_triangle !== w.end_of_triangle) begin
			$error("end_of_triangle exp %b got %b", w.end_of_triangle, got.end_of_triangle);
			err_n++;
		end
		if (got.last_of_run !== w.last_of_run) begin
			$error("last_of_run exp %b got %b", w.last_of_run, got.last_of_run);
			err_n++;
		end
	endfunction
endclass

module tb_triangle_near_w_clipper;
	import tnwc_pkg::*;

	// Cycles without any accepted request before the run is declared hung.
	localparam int STALL_LIMIT = 5000;
	// Long enough for the worst clipped triangle to clear the back end.
	localparam int SETTLE_CYCLES = 300;
	localparam int HOLD_CYCLES = 400;
	localparam logic [31:0] W_MIN = 32'h8000_0000;
	localparam logic [31:0] W_MAX = 32'h7fff_ffff;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	vin_t        din;
	logic        empty;
	logic        pop;
	vout_t       dout;
	logic        cfg_we;
	logic [31:0] cfg_wdata;

	clip_scoreboard sb;
	bit idle_on;
	bit hold_off;
	int stall_cnt;

	triangle_near_w_clipper uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.din(din),
		.empty(empty),
		.pop(pop),
		.dout(dout),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Push one vertex request; hold it on din until full drops at an edge.
	task automatic send_vertex(vin_t v);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		din <= v;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.take_vertex(v);
	endtask

	task automatic send_triangle(vin_t a, vin_t b, vin_t c);
		send_vertex(a);
		send_vertex(b);
		send_vertex(c);
	endtask

	// Drop push and wait until every expected result has been popped.
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (sb.pending() > 0)
			@(posedge clk);
	endtask

	// Write the threshold only with the block idle: drained, then a settle
	// wait before the write.
	task automatic set_threshold(logic [31:0] t);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= t;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.thr = t;
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 20000)) - 10000) <<< 8;
			2: return ($urandom_range(0, 1)) ? W_MIN : W_MAX;
			default: return 32'($signed($urandom_range(0, 2000)) - 1000);
		endcase
	endfunction

	// Pick a w on the wanted side of the current threshold (always bad at max).
	function automatic logic [31:0] pick_w(bit want_bad);
		longint t, lo, hi, span, d;
		t = $signed(sb.thr);
		lo = -64'sd2147483648;
		hi = 64'sd2147483647;
		d = longint'($urandom_range(0, 5000));
		if (want_bad || t == hi) begin
			span = t - lo + 1;
			case ($urandom_range(0, 4))
				0: return 32'(t);
				1: return 32'((t - d < lo) ? lo : t - d);
				2: return W_MIN;
				default: return 32'(lo + longint'({$urandom, $urandom} % span));
			endcase
		end
		span = hi - t;
		case ($urandom_range(0, 4))
			0: return 32'(t + 1);
			1: return 32'((t + 1 + d > hi) ? hi : t + 1 + d);
			2: return W_MAX;
			default: return 32'(t + 1 + longint'({$urandom, $urandom} % span));
		endcase
	endfunction

	function automatic vin_t make_vertex(bit want_bad);
		vin_t v;
		v.in_x = rand_coord();
		v.in_y = rand_coord();
		v.in_z = rand_coord();
		v.in_w = pick_w(want_bad);
		return v;
	endfunction

	function automatic vin_t vtx(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [31:0] w);
		vin_t v;
		v.in_x = x;
		v.in_y = y;
		v.in_z = z;
		v.in_w = w;
		return v;
	endfunction

	// Mostly triangles with one or two bad corners, where the divider works.
	task automatic random_triangles(int n, bit force_one_bad);
		bit b [3];
		int pick;
		for (int k = 0; k < n; k++) begin
			pick = force_one_bad ? 1 : $urandom_range(0, 9);
			for (int i = 0; i < 3; i++)
				b[i] = 1'b0;
			if (pick <= 4) begin
				b[$urandom_range(0, 2)] = 1'b1;
			end else if (pick <= 7) begin
				b[0] = 1'b1;
				b[1] = 1'b1;
				b[2] = 1'b1;
				b[$urandom_range(0, 2)] = 1'b0;
			end else if (pick == 8) begin
				for (int i = 0; i < 3; i++)
					b[i] = $urandom_range(0, 1);
			end
			send_triangle(make_vertex(b[0]), make_vertex(b[1]), make_vertex(b[2]));
		end
	endtask

	// Receiver: check each popped result, idle in bursts, honor a long hold.
	initial begin
		int burst;
		burst = 0;
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (pop && !empty)
				sb.check_vertex(dout);
			if (hold_off) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end else begin
				if (idle_on && burst == 0 && $urandom_range(0, 3) == 0)
					burst = $urandom_range(1, 12);
				if (burst > 0) begin
					pop <= 1'b0;
					burst--;
				end else begin
					pop <= 1'b1;
				end
			end
		end
	end

	// Watchdog: abort when no request moves on either side for too long.
	initial begin
		stall_cnt = 0;
		forever begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty)) begin
				stall_cnt = 0;
			end else begin
				stall_cnt++;
				if (stall_cnt >= STALL_LIMIT) begin
					$display("[triangle_near_w_clipper] ERROR");
					$finish;
				end
			end
		end
	end

	initial begin
		sb = new();
		arst_n = 1'b0;
		push = 1'b0;
		din = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		idle_on = 1'b1;
		hold_off = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset threshold of 655.
		// No corner clipped, with coordinate extremes.
		send_triangle(vtx(W_MAX, W_MIN, 0, 32'd656), vtx(W_MIN, W_MAX, W_MAX, W_MAX),
			vtx(0, 0, W_MIN, 32'd65536));
		// All corners clipped, one sitting exactly on the plane: dropped.
		send_triangle(vtx(1, 2, 3, 32'd655), vtx(4, 5, 6, W_MIN), vtx(7, 8, 9, 0));
		// One bad corner in each position.
		send_triangle(vtx(W_MIN, W_MAX, 100, W_MIN), vtx(W_MAX, W_MIN, -100, W_MAX),
			vtx(65536, -65536, 0, 32'd656));
		send_triangle(vtx(10, 20, 30, 32'd70000), vtx(-5, 7, 9, 32'd655),
			vtx(3, 3, 3, 32'd131072));
		send_triangle(vtx(W_MAX, W_MAX, W_MAX, W_MAX), vtx(1000, -1000, 5, 32'd5000),
			vtx(W_MIN, W_MIN, W_MIN, W_MIN));
		// Two bad corners in each position.
		send_triangle(vtx(W_MAX, 0, W_MIN, W_MAX), vtx(0, 0, 0, 0), vtx(1, 1, 1, -1));
		send_triangle(vtx(-7, 3, 11, 32'd600), vtx(W_MIN, W_MAX, 0, W_MAX),
			vtx(9, -9, 9, W_MIN));
		send_triangle(vtx(2, 4, 6, 32'd655), vtx(-1, -3, -5, -32'd65536),
			vtx(W_MIN, W_MAX, W_MIN, 32'd656));

		random_triangles(8, 1'b0);

		// Receiver holds off while the sender keeps pushing: fills the block.
		drain();
		hold_off = 1'b1;
		random_triangles(6, 1'b1);
		// Sender pauses until every result is out.
		drain();

		set_threshold(32'd0);
		random_triangles(9, 1'b0);
		set_threshold(W_MIN);
		random_triangles(7, 1'b0);
		set_threshold(W_MAX);
		random_triangles(4, 1'b0);
		set_threshold(-32'sd65536);
		random_triangles(9, 1'b0);
		set_threshold($urandom);
		random_triangles(8, 1'b0);

		// Last stretch without idling on either side.
		set_threshold(32'd65536);
		idle_on = 1'b0;
		random_triangles(10, 1'b0);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d triangles and %0d result vertices over seven thresholds,",
			sb.tri_n, sb.emit_n);
		$display("including a long output hold with the input stalled.");
		if (sb.err_n == 0 && sb.pending() == 0)
			$display("[triangle_near_w_clipper] OK");
		else
			$display("[triangle_near_w_clipper] ERROR");
		$finish;
	end
endmodule
